// ----- rtl/ppvi_pkg.sv -----
`timescale 1ns / 1ps

package ppvi_pkg;

    // loop and output constants
    localparam int CONTROL_PERIOD = 40;
    localparam int OUTPUT_LIMIT   = 200;
    localparam int POSITION_WIDTH = 32;

    // field widths
    localparam int TICK_W  = 6;
    localparam int DELTA_W = 16;
    localparam int ERR_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int DRIVE_W = 9;
    localparam int CFG_IDX_W = 2;

    // target minus position, one bit of headroom over the wider operand
    localparam int DIFF_W = ((POSITION_WIDTH > ERR_W) ? POSITION_WIDTH : ERR_W) + 1;

    // integral increment divider: quotient below 1280 fits 11 bits
    localparam int QUO_W = 11;
    localparam int REM_W = 42;
    localparam int DSH_W = ERR_W + 1 + QUO_W - 1;
    localparam int CNT_W = $clog2(QUO_W);

    // shared multiplier and drive accumulator
    localparam int PROD_W = GAIN_W + 1 + ERR_W + 1;
    localparam int ACC_W  = 60;

    typedef logic signed [POSITION_WIDTH-1:0] t_pos;
    typedef logic signed [DIFF_W-1:0]         t_diff;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD = 2'd2;

    // microprogram steps
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_IDLE     = 4'd0;
    localparam t_step ST_ERR      = 4'd1;
    localparam t_step ST_DIV_INIT = 4'd2;
    localparam t_step ST_DIV_STEP = 4'd3;
    localparam t_step ST_INTEG    = 4'd4;
    localparam t_step ST_MUL_P    = 4'd5;
    localparam t_step ST_MUL_I    = 4'd6;
    localparam t_step ST_MUL_D    = 4'd7;
    localparam t_step ST_ACC_D    = 4'd8;
    localparam t_step ST_EMIT     = 4'd9;

    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_WAIT_IN,
        SQ_LOOP,
        SQ_WAIT_OUT
    } t_seq_mode;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_ERR,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_INTEG,
        DP_EMIT
    } t_dp_op;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD,
        ACC_ADD_SH8
    } t_acc_op;

    typedef enum logic [1:0] {
        MS_KP,
        MS_KI,
        MS_KD
    } t_mul_sel;

    typedef struct packed {
        logic      take_in;
        t_seq_mode seq;
        t_step     target;
        t_dp_op    dp;
        t_acc_op   acc;
        t_mul_sel  msel;
    } t_uword;

    typedef struct packed {
        logic in_go;
        logic div_more;
        logic out_free;
    } t_seq_status;

    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        w         = '0;
        w.take_in = 1'b0;
        w.seq     = SQ_NEXT;
        w.target  = ST_IDLE;
        w.dp      = DP_NONE;
        w.acc     = ACC_HOLD;
        w.msel    = MS_KP;
        case (pc)
            ST_IDLE: begin
                w.take_in = 1'b1;
                w.seq     = SQ_WAIT_IN;
                w.target  = ST_ERR;
            end
            ST_ERR: begin
                w.dp = DP_ERR;
            end
            ST_DIV_INIT: begin
                w.dp = DP_DIV_INIT;
            end
            ST_DIV_STEP: begin
                w.seq    = SQ_LOOP;
                w.target = ST_DIV_STEP;
                w.dp     = DP_DIV_STEP;
            end
            ST_INTEG: begin
                w.dp = DP_INTEG;
            end
            ST_MUL_P: begin
                w.acc  = ACC_CLR;
                w.msel = MS_KP;
            end
            ST_MUL_I: begin
                w.acc  = ACC_ADD_SH8;
                w.msel = MS_KI;
            end
            ST_MUL_D: begin
                w.acc  = ACC_ADD;
                w.msel = MS_KD;
            end
            ST_ACC_D: begin
                w.acc = ACC_ADD_SH8;
            end
            ST_EMIT: begin
                w.seq    = SQ_WAIT_OUT;
                w.target = ST_IDLE;
                w.dp     = DP_EMIT;
            end
            default: begin
                w.seq    = SQ_NEXT;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/ppvi_seq.sv -----
`timescale 1ns / 1ps

module ppvi_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ppvi_pkg::t_seq_status i_status,
    output ppvi_pkg::t_uword      o_uword
);

    ppvi_pkg::t_step  r_pc;
    ppvi_pkg::t_step  n_pc;
    ppvi_pkg::t_uword uw;

    assign uw      = ppvi_pkg::ucode(r_pc);
    assign o_uword = uw;

    always_comb begin
        case (uw.seq)
            ppvi_pkg::SQ_NEXT: begin
                n_pc = r_pc + ppvi_pkg::t_step'(1);
            end
            ppvi_pkg::SQ_WAIT_IN: begin
                n_pc = i_status.in_go ? uw.target : r_pc;
            end
            ppvi_pkg::SQ_LOOP: begin
                n_pc = i_status.div_more ? uw.target : r_pc + ppvi_pkg::t_step'(1);
            end
            ppvi_pkg::SQ_WAIT_OUT: begin
                n_pc = i_status.out_free ? uw.target : r_pc;
            end
            default: begin
                n_pc = ppvi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ppvi_pkg::ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- rtl/position_pid_variable_integral.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        to block   i_in_valid / o_in_stall    i_encoder_delta, i_target_position
// out       from block o_out_valid / i_out_stall  o_drive_value, o_position_error
// cfg       to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a tick that does not close a control period is taken in the idle step and gives no item
// a control tick runs the microprogram: error, 11-step restoring divide, integral, then
// three passes through the one shared 17x33 multiplier, accumulation and the output
// register; most of the steps of a control tick are in the divider
// the input is stalled while the program runs; the last step holds while the output register
// is full and stalled; synchronous active-low reset clears state, gains and output valid

module position_pid_variable_integral (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [ppvi_pkg::DELTA_W-1:0] i_encoder_delta,
    input  logic signed [ppvi_pkg::ERR_W-1:0]   i_target_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ppvi_pkg::DRIVE_W-1:0] o_drive_value,
    output logic signed [ppvi_pkg::ERR_W-1:0]   o_position_error,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ppvi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ppvi_pkg::GAIN_W-1:0]         i_cfg_data
);

    localparam logic signed [ppvi_pkg::ACC_W-1:0] LIM_HI = ppvi_pkg::ACC_W'(ppvi_pkg::OUTPUT_LIMIT);
    localparam logic signed [ppvi_pkg::ACC_W-1:0] LIM_LO = -LIM_HI;

    ppvi_pkg::t_uword      uw;
    ppvi_pkg::t_seq_status status;

    // gains
    logic [ppvi_pkg::GAIN_W-1:0] r_kp;
    logic [ppvi_pkg::GAIN_W-1:0] r_ki;
    logic [ppvi_pkg::GAIN_W-1:0] r_kd;

    // loop state
    ppvi_pkg::t_pos                    r_pos;
    logic [ppvi_pkg::TICK_W-1:0]       r_tick;
    logic [ppvi_pkg::TICK_W-1:0]       n_tick;
    logic signed [ppvi_pkg::ERR_W-1:0] r_last;
    logic signed [ppvi_pkg::ERR_W-1:0] r_integral;

    // working registers
    logic signed [ppvi_pkg::ERR_W-1:0]  r_target;
    logic signed [ppvi_pkg::ERR_W-1:0]  r_err;
    logic [ppvi_pkg::REM_W-1:0]         r_rem;
    logic [ppvi_pkg::DSH_W-1:0]         r_dsh;
    logic [ppvi_pkg::QUO_W-1:0]         r_quo;
    logic [ppvi_pkg::CNT_W-1:0]         r_cnt;
    logic signed [ppvi_pkg::PROD_W-1:0] r_prod;
    logic signed [ppvi_pkg::ACC_W-1:0]  r_acc;

    // output register
    logic                                r_out_valid;
    logic signed [ppvi_pkg::DRIVE_W-1:0] r_drive;
    logic signed [ppvi_pkg::ERR_W-1:0]   r_perr;

    logic                                in_acc;
    logic                                tick_hit;
    logic                                out_free;
    ppvi_pkg::t_diff                     diff;
    logic signed [ppvi_pkg::ERR_W-1:0]   err_sat;
    logic [ppvi_pkg::ERR_W-1:0]          mag;
    logic [ppvi_pkg::DSH_W-1:0]          rem_ext;
    logic                                div_ge;
    logic signed [ppvi_pkg::QUO_W:0]     inc;
    logic signed [ppvi_pkg::ERR_W:0]     isum;
    logic signed [ppvi_pkg::ERR_W-1:0]   integ_sat;
    logic signed [ppvi_pkg::GAIN_W:0]    mul_a;
    logic signed [ppvi_pkg::ERR_W:0]     mul_b;
    logic signed [ppvi_pkg::ACC_W-1:0]   acc_rnd;
    logic signed [ppvi_pkg::ACC_W-1:0]   drv_q;
    logic signed [ppvi_pkg::ACC_W-1:0]   drv_cl;

    ppvi_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uw)
    );

    // handshakes
    assign in_acc      = i_in_valid && uw.take_in;
    assign o_in_stall  = !uw.take_in;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // 6-bit tick counter, back to zero when it closes a period at the control count
    assign n_tick   = r_tick + ppvi_pkg::TICK_W'(1);
    assign tick_hit = (n_tick >= ppvi_pkg::TICK_W'(ppvi_pkg::CONTROL_PERIOD));

    assign status.in_go    = in_acc && tick_hit;
    assign status.div_more = (r_cnt != '0);
    assign status.out_free = out_free;

    // error, saturated to 32 bits
    assign diff = ppvi_pkg::t_diff'(r_target) - ppvi_pkg::t_diff'(r_pos);

    always_comb begin
        if (!diff[ppvi_pkg::DIFF_W-1] && (|diff[ppvi_pkg::DIFF_W-2:ppvi_pkg::ERR_W-1])) begin
            err_sat = 32'sh7FFF_FFFF;
        end else if (diff[ppvi_pkg::DIFF_W-1]
                     && !(&diff[ppvi_pkg::DIFF_W-2:ppvi_pkg::ERR_W-1])) begin
            err_sat = 32'sh8000_0000;
        end else begin
            err_sat = diff[ppvi_pkg::ERR_W-1:0];
        end
    end

    // |e|, the most negative error maps to 2^31
    assign mag = r_err[ppvi_pkg::ERR_W-1] ? ppvi_pkg::ERR_W'(-r_err) : ppvi_pkg::ERR_W'(r_err);

    // restoring divide step: 1280*|e| / (|e|+5), one quotient bit per cycle
    assign rem_ext = ppvi_pkg::DSH_W'(r_rem);
    assign div_ge  = (rem_ext >= r_dsh);

    // integral increment carries the sign of the error, truncation toward zero
    always_comb begin
        if (r_err[ppvi_pkg::ERR_W-1]) begin
            inc = -$signed({1'b0, r_quo});
        end else begin
            inc = $signed({1'b0, r_quo});
        end
        isum = (ppvi_pkg::ERR_W + 1)'(r_integral) + (ppvi_pkg::ERR_W + 1)'(inc);
        if (isum[ppvi_pkg::ERR_W] != isum[ppvi_pkg::ERR_W-1]) begin
            integ_sat = isum[ppvi_pkg::ERR_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            integ_sat = isum[ppvi_pkg::ERR_W-1:0];
        end
    end

    // shared multiplier operands
    always_comb begin
        case (uw.msel)
            ppvi_pkg::MS_KP: begin
                mul_a = {1'b0, r_kp};
                mul_b = (ppvi_pkg::ERR_W + 1)'(r_err);
            end
            ppvi_pkg::MS_KI: begin
                mul_a = {1'b0, r_ki};
                mul_b = (ppvi_pkg::ERR_W + 1)'(r_integral);
            end
            ppvi_pkg::MS_KD: begin
                mul_a = {1'b0, r_kd};
                mul_b = (ppvi_pkg::ERR_W + 1)'(r_err) - (ppvi_pkg::ERR_W + 1)'(r_last);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Q.16 sum to integer toward zero, then clamp
    always_comb begin
        acc_rnd = r_acc + (r_acc[ppvi_pkg::ACC_W-1] ? ppvi_pkg::ACC_W'(65535) : '0);
        drv_q   = acc_rnd >>> 16;
        if (drv_q > LIM_HI) begin
            drv_cl = LIM_HI;
        end else if (drv_q < LIM_LO) begin
            drv_cl = LIM_LO;
        end else begin
            drv_cl = drv_q;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_pos       <= '0;
            r_tick      <= '0;
            r_last      <= '0;
            r_integral  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ppvi_pkg::REG_KP: r_kp <= i_cfg_data;
                    ppvi_pkg::REG_KI: r_ki <= i_cfg_data;
                    ppvi_pkg::REG_KD: r_kd <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_pos  <= r_pos + ppvi_pkg::t_pos'(i_encoder_delta);
                r_tick <= tick_hit ? '0 : n_tick;
            end
            if (uw.dp == ppvi_pkg::DP_INTEG) begin
                r_integral <= integ_sat;
            end
            if (uw.dp == ppvi_pkg::DP_EMIT && out_free) begin
                r_last      <= r_err;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_target <= i_target_position;
        end
        case (uw.dp)
            ppvi_pkg::DP_ERR: begin
                r_err <= err_sat;
            end
            ppvi_pkg::DP_DIV_INIT: begin
                r_rem <= (ppvi_pkg::REM_W'(mag) << 10) + (ppvi_pkg::REM_W'(mag) << 8);
                r_dsh <= ppvi_pkg::DSH_W'({1'b0, mag} + (ppvi_pkg::ERR_W + 1)'(5))
                         << (ppvi_pkg::QUO_W - 1);
                r_quo <= '0;
                r_cnt <= ppvi_pkg::CNT_W'(ppvi_pkg::QUO_W - 1);
            end
            ppvi_pkg::DP_DIV_STEP: begin
                if (div_ge) begin
                    r_rem <= r_rem - r_dsh[ppvi_pkg::REM_W-1:0];
                end
                r_quo <= {r_quo[ppvi_pkg::QUO_W-2:0], div_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - ppvi_pkg::CNT_W'(1);
            end
            ppvi_pkg::DP_EMIT: begin
                if (out_free) begin
                    r_drive <= drv_cl[ppvi_pkg::DRIVE_W-1:0];
                    r_perr  <= r_err;
                end
            end
            default: ;
        endcase

        r_prod <= mul_a * mul_b;

        case (uw.acc)
            ppvi_pkg::ACC_CLR:     r_acc <= '0;
            ppvi_pkg::ACC_ADD:     r_acc <= r_acc + ppvi_pkg::ACC_W'(r_prod);
            ppvi_pkg::ACC_ADD_SH8: r_acc <= r_acc + (ppvi_pkg::ACC_W'(r_prod) <<< 8);
            default:               r_acc <= r_acc;
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_drive_value    = r_drive;
    assign o_position_error = r_perr;

endmodule

// ----- rtl/ppvi_checker.sv -----
`timescale 1ns / 1ps

module ppvi_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic signed [ppvi_pkg::DELTA_W-1:0] i_encoder_delta,
    input logic signed [ppvi_pkg::ERR_W-1:0]   i_target_position,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [ppvi_pkg::DRIVE_W-1:0] o_drive_value,
    input logic signed [ppvi_pkg::ERR_W-1:0]   o_position_error,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic [ppvi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input logic [ppvi_pkg::GAIN_W-1:0]         i_cfg_data
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // reset leaves the sequencer waiting for an item
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive_value)
                                        && $stable(o_position_error))
        else $error("stalled item changed");

    // drive stays inside the clamp
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (ppvi_pkg::OUTPUT_LIMIT > 255)
                        || ((o_drive_value <= ppvi_pkg::OUTPUT_LIMIT)
                            && (o_drive_value >= -ppvi_pkg::OUTPUT_LIMIT)))
        else $error("drive outside limit");

endmodule

bind position_pid_variable_integral ppvi_checker u_ppvi_checker (.*);
